// File: rtl/core/dife_pkg.sv
package dife_pkg;

  localparam int unsigned ImageBytes = 174848;
  localparam int unsigned AddrW = 18;
  localparam int unsigned MaxDirSectors = 683;

  typedef enum logic [2:0] {
    PH_SEARCH   = 3'd0,
    PH_DATA     = 3'd1,
    PH_END      = 3'd2,
    PH_NOTFOUND = 3'd3,
    PH_BADLINK  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OUT_DATA     = 2'd0,
    OUT_END      = 2'd1,
    OUT_NOTFOUND = 2'd2,
    OUT_BADLINK  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_NAME_LO   = 2'd0,
    CFG_NAME_HI   = 2'd1,
    CFG_NAME_LEN  = 2'd2,
    CFG_SKIP_LOAD = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIR_LINK_T, ST_DIR_LINK_S,
    ST_ENT_TYPE, ST_ENT_NAME, ST_ENT_FT, ST_ENT_FS,
    ST_DAT_LT, ST_DAT_LS, ST_DAT_BYTE,
    ST_RESULT
  } seq_t;

  // Memory port request from sequencer
  typedef struct packed {
    logic             rd;
    logic [AddrW-1:0] addr;
  } mem_req_t;

  function automatic logic link_valid(input logic [7:0] t, input logic [7:0] s);
    logic [4:0] n;
    begin
      if (t <= 8'd17) n = 5'd21;
      else if (t <= 8'd24) n = 5'd19;
      else if (t <= 8'd30) n = 5'd18;
      else n = 5'd17;
      link_valid = (t >= 8'd1) && (t <= 8'd35) && (s < {3'd0, n});
    end
  endfunction

  // First sector number of a track (valid tracks only)
  function automatic logic [9:0] track_first(input logic [5:0] t);
    logic [9:0] tm;
    begin
      tm = {4'd0, t} - 10'd1;
      if (t <= 6'd17) track_first = 10'(tm * 10'd21);
      else if (t <= 6'd24) track_first = 10'(10'd357 + (tm - 10'd17) * 10'd19);
      else if (t <= 6'd30) track_first = 10'(10'd490 + (tm - 10'd24) * 10'd18);
      else track_first = 10'(10'd598 + (tm - 10'd30) * 10'd17);
    end
  endfunction

endpackage

// File: rtl/core/dife_mem.sv
module dife_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [dife_pkg::AddrW-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  dife_pkg::mem_req_t        req,
  output logic [7:0]                rd_data
);

  logic [7:0] mem [dife_pkg::ImageBytes];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// File: rtl/core/dife_seq.sv
module dife_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       restart,
  input  logic [127:0]               name,
  input  logic [4:0]                 name_len,
  input  logic                       skip_load,
  input  logic [7:0]                 rd_data,
  output dife_pkg::mem_req_t         req,
  output logic                       busy,
  output logic                       done,
  output logic [7:0]                 res_byte,
  output logic [1:0]                 res_outcome
);

  dife_pkg::seq_t   st_r, st_nxt;
  dife_pkg::phase_t ph_r, ph_nxt;
  logic [5:0]  trk_r, trk_nxt;
  logic [4:0]  sec_r, sec_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [1:0]  skip_r, skip_nxt;
  logic [2:0]  ent_r, ent_nxt;
  logic [3:0]  chr_r, chr_nxt;
  logic [9:0]  visits_r, visits_nxt;
  logic [7:0]  lt_r, lt_nxt;
  logic [7:0]  tmp_r, tmp_nxt;
  logic [17:0] base_r, base_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  oc_r, oc_nxt;
  logic [4:0]  nlen;
  logic [7:0]  ch, want;
  logic [7:0]  last;
  logic [17:0] ebase;

  assign nlen = (name_len > 5'd16) ? 5'd16 : name_len;
  assign ch = (rd_data == 8'hA0 || rd_data == 8'h20) ? 8'h5F : rd_data;
  assign want = name[{chr_r, 3'd0} +: 8];
  assign last = (lt_r != 8'd0) ? 8'd255 : tmp_r;
  assign ebase = base_r + 18'd2 + {10'd0, ent_r, 5'd0};

  always_ff @(posedge clk) begin
    base_r <= {dife_pkg::track_first(trk_nxt) + {5'd0, sec_nxt}, 8'd0};
    lt_r   <= lt_nxt;
    tmp_r  <= tmp_nxt;
    byte_r <= byte_nxt;
    oc_r   <= oc_nxt;
    ent_r  <= ent_nxt;
    chr_r  <= chr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dife_pkg::ST_IDLE;
      ph_r <= dife_pkg::PH_SEARCH;
      trk_r <= 6'd18;
      sec_r <= 5'd1;
      pos_r <= 8'd2;
      skip_r <= 2'd0;
      visits_r <= 10'd1;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      trk_r <= trk_nxt;
      sec_r <= sec_nxt;
      pos_r <= pos_nxt;
      skip_r <= skip_nxt;
      visits_r <= visits_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; trk_nxt = trk_r; sec_nxt = sec_r;
    pos_nxt = pos_r; skip_nxt = skip_r; ent_nxt = ent_r; chr_nxt = chr_r;
    visits_nxt = visits_r; lt_nxt = lt_r; tmp_nxt = tmp_r;
    byte_nxt = byte_r; oc_nxt = oc_r;
    unique case (st_r)
      dife_pkg::ST_IDLE: begin
        if (restart) begin
          ph_nxt = dife_pkg::PH_SEARCH;
          trk_nxt = 6'd18; sec_nxt = 5'd1; visits_nxt = 10'd1;
        end else if (start) begin
          unique case (ph_r)
            dife_pkg::PH_SEARCH: begin
              trk_nxt = 6'd18; sec_nxt = 5'd1; visits_nxt = 10'd1;
              ent_nxt = 3'd0; st_nxt = dife_pkg::ST_ENT_TYPE;
            end
            dife_pkg::PH_DATA: st_nxt = dife_pkg::ST_DAT_LT;
            default: begin
              byte_nxt = 8'd0;
              oc_nxt = (ph_r == dife_pkg::PH_END) ? dife_pkg::OUT_END :
                       (ph_r == dife_pkg::PH_NOTFOUND) ? dife_pkg::OUT_NOTFOUND :
                       dife_pkg::OUT_BADLINK;
              st_nxt = dife_pkg::ST_RESULT;
            end
          endcase
        end
      end
      dife_pkg::ST_ENT_TYPE: begin
        if ((rd_data & 8'h83) == 8'h82) begin
          chr_nxt = 4'd0;
          st_nxt = (nlen == 5'd0) ? dife_pkg::ST_ENT_FT : dife_pkg::ST_ENT_NAME;
        end else if (ent_r == 3'd7) begin
          st_nxt = dife_pkg::ST_DIR_LINK_T;
        end else begin
          ent_nxt = ent_r + 3'd1;
        end
      end
      dife_pkg::ST_ENT_NAME: begin
        if (ch != want) begin
          if (ent_r == 3'd7) st_nxt = dife_pkg::ST_DIR_LINK_T;
          else begin
            ent_nxt = ent_r + 3'd1; st_nxt = dife_pkg::ST_ENT_TYPE;
          end
        end else if ({1'b0, chr_r} + 5'd1 == nlen) begin
          st_nxt = dife_pkg::ST_ENT_FT;
        end else begin
          chr_nxt = chr_r + 4'd1;
        end
      end
      dife_pkg::ST_ENT_FT: begin
        lt_nxt = rd_data; st_nxt = dife_pkg::ST_ENT_FS;
      end
      dife_pkg::ST_ENT_FS: begin
        if (!dife_pkg::link_valid(lt_r, rd_data)) begin
          ph_nxt = dife_pkg::PH_BADLINK; oc_nxt = dife_pkg::OUT_BADLINK;
          byte_nxt = 8'd0; st_nxt = dife_pkg::ST_RESULT;
        end else begin
          trk_nxt = lt_r[5:0]; sec_nxt = rd_data[4:0]; pos_nxt = 8'd2;
          skip_nxt = skip_load ? 2'd2 : 2'd0;
          ph_nxt = dife_pkg::PH_DATA; st_nxt = dife_pkg::ST_DAT_LT;
        end
      end
      dife_pkg::ST_DIR_LINK_T: begin
        lt_nxt = rd_data; st_nxt = dife_pkg::ST_DIR_LINK_S;
      end
      dife_pkg::ST_DIR_LINK_S: begin
        byte_nxt = 8'd0;
        if (lt_r == 8'd0) begin
          ph_nxt = dife_pkg::PH_NOTFOUND; oc_nxt = dife_pkg::OUT_NOTFOUND;
          st_nxt = dife_pkg::ST_RESULT;
        end else if (!dife_pkg::link_valid(lt_r, rd_data) ||
                     visits_r >= 10'(dife_pkg::MaxDirSectors)) begin
          ph_nxt = dife_pkg::PH_BADLINK; oc_nxt = dife_pkg::OUT_BADLINK;
          st_nxt = dife_pkg::ST_RESULT;
        end else begin
          trk_nxt = lt_r[5:0]; sec_nxt = rd_data[4:0];
          visits_nxt = visits_r + 10'd1; ent_nxt = 3'd0;
          st_nxt = dife_pkg::ST_ENT_TYPE;
        end
      end
      dife_pkg::ST_DAT_LT: begin
        lt_nxt = rd_data; st_nxt = dife_pkg::ST_DAT_LS;
      end
      dife_pkg::ST_DAT_LS: begin
        tmp_nxt = rd_data;
        if (pos_r >= 8'd2 && pos_r <= ((lt_r != 8'd0) ? 8'd255 : rd_data)) begin
          st_nxt = dife_pkg::ST_DAT_BYTE;
        end else if (lt_r == 8'd0) begin
          ph_nxt = dife_pkg::PH_END; oc_nxt = dife_pkg::OUT_END;
          byte_nxt = 8'd0; st_nxt = dife_pkg::ST_RESULT;
        end else if (!dife_pkg::link_valid(lt_r, rd_data)) begin
          ph_nxt = dife_pkg::PH_BADLINK; oc_nxt = dife_pkg::OUT_BADLINK;
          byte_nxt = 8'd0; st_nxt = dife_pkg::ST_RESULT;
        end else begin
          trk_nxt = lt_r[5:0]; sec_nxt = rd_data[4:0]; pos_nxt = 8'd2;
          st_nxt = dife_pkg::ST_DAT_LT;
        end
      end
      dife_pkg::ST_DAT_BYTE: begin
        pos_nxt = pos_r + 8'd1;
        if (skip_r != 2'd0) begin
          skip_nxt = skip_r - 2'd1;
          st_nxt = (pos_r == last) ? dife_pkg::ST_DAT_LT : dife_pkg::ST_DAT_BYTE;
        end else begin
          byte_nxt = rd_data; oc_nxt = dife_pkg::OUT_DATA;
          st_nxt = dife_pkg::ST_RESULT;
        end
      end
      dife_pkg::ST_RESULT: st_nxt = dife_pkg::ST_IDLE;
      default: st_nxt = dife_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.rd = 1'b1;
    req.addr = base_r;
    unique case (st_nxt)
      dife_pkg::ST_ENT_TYPE: req.addr = base_r + 18'd2 + {10'd0, ent_nxt, 5'd0};
      dife_pkg::ST_ENT_NAME: req.addr = ebase + 18'd3 + {14'd0, chr_nxt};
      dife_pkg::ST_ENT_FT:   req.addr = ebase + 18'd1;
      dife_pkg::ST_ENT_FS:   req.addr = ebase + 18'd2;
      dife_pkg::ST_DIR_LINK_S, dife_pkg::ST_DAT_LS: req.addr = base_r + 18'd1;
      dife_pkg::ST_DAT_BYTE: req.addr = base_r + {10'd0, pos_nxt};
      default: req.addr = base_r;
    endcase
    if (st_nxt == dife_pkg::ST_ENT_TYPE || st_nxt == dife_pkg::ST_DIR_LINK_T ||
        st_nxt == dife_pkg::ST_DAT_LT) begin
      req.addr = (st_nxt == dife_pkg::ST_ENT_TYPE) ?
        {dife_pkg::track_first(trk_nxt) + {5'd0, sec_nxt}, 8'd0} + 18'd2 +
          {10'd0, ent_nxt, 5'd0} :
        {dife_pkg::track_first(trk_nxt) + {5'd0, sec_nxt}, 8'd0};
    end
  end

  assign busy = (st_r != dife_pkg::ST_IDLE);
  assign done = (st_r == dife_pkg::ST_RESULT);
  assign res_byte = byte_r;
  assign res_outcome = oc_r;

endmodule

// File: rtl/core/disk_image_file_extractor_unit.sv
// channel | dir | payload
// in_     | in  | tdata[17:0] image_address, tdata[25:18] image_byte; tuser op
// out_    | out | tdata[7:0] file_byte; tuser outcome
// cfg_    | in  | cfg_index[1:0], cfg_data[63:0]
// A store writes one in-range image byte. A data pull reads the two link bytes,
// then one file byte, then presents the result; a block change or skipped bytes add reads.
// A directory search reads one byte per cycle until the name matches or the chain ends.
// rst_n is synchronous; the image keeps its content. A held result stalls input.
module disk_image_file_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // image_address, image_byte, zero fill
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // file_byte
  output logic [1:0]  out_tuser,  // outcome
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [127:0] name_r;
  logic [4:0]   nlen_r;
  logic         skip_r;
  logic         busy, done, in_acc, wr_en;
  logic [7:0]   rd_data, res_byte;
  logic [1:0]   res_oc;
  logic         ov_r;
  logic [7:0]   ob_r;
  logic [1:0]   oo_r;
  dife_pkg::mem_req_t req;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy && !ov_r;
  assign in_acc = in_tvalid && in_tready;
  assign wr_en = in_acc && !in_tuser &&
                 (in_tdata[17:0] < 18'(dife_pkg::ImageBytes));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= '0; nlen_r <= '0; skip_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dife_pkg::CFG_NAME_LO:   name_r[63:0] <= cfg_data;
          dife_pkg::CFG_NAME_HI:   name_r[127:64] <= cfg_data;
          dife_pkg::CFG_NAME_LEN:  nlen_r <= cfg_data[4:0];
          dife_pkg::CFG_SKIP_LOAD: skip_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (done) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      ob_r <= res_byte; oo_r <= res_oc;
    end
  end

  dife_mem u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(in_tdata[17:0]), .wr_data(in_tdata[25:18]),
    .req(req), .rd_data(rd_data)
  );

  dife_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(in_acc && in_tuser),
    .restart(in_acc && !in_tuser), .name(name_r), .name_len(nlen_r),
    .skip_load(skip_r), .rd_data(rd_data), .req(req), .busy(busy), .done(done),
    .res_byte(res_byte), .res_outcome(res_oc)
  );

  assign out_tvalid = ov_r;
  assign out_tdata = ob_r;
  assign out_tuser = oo_r;

endmodule

// File: rtl/core/dife_checker.sv
module dife_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dife_pkg::OUT_DATA |-> out_tdata == 8'd0)
    else $error("status word carries data");

endmodule

bind disk_image_file_extractor_unit dife_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
